// ===== design/bmpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmpd_pkg;

  // image size limits
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
  // bytes in a padded row, 4 bytes per pixel worst case
  localparam int unsigned ROW_BYTE_W = $clog2(4 * MAX_WIDTH + 1);

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned STATUS_W = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PIXEL      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INFO_SHORT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FORMAT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 3'd5;

  localparam logic [7:0] MAGIC_B       = 8'h42;
  localparam logic [7:0] MAGIC_M       = 8'h4d;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;
  localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
  localparam logic [32:0] FILE_HDR_LEN  = 33'd14;
  localparam logic [15:0] BPP_24        = 16'd24;
  localparam logic [15:0] BPP_32        = 16'd32;

  typedef struct packed {
    logic [31:0]         argb;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ===== design/bmpd_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmpd_skid
  import bmpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop       = main_valid_r && out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  // registered: no path from out_ready to the input side
  assign room      = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_nxt = push;
      if (push) begin
        main_nxt = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

// ===== design/bmp_stream_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data_byte[7:0], in_file_start
// out_      output     out_valid / out_ready  out_pixel_argb[31:0], out_pixel_x[11:0],
//                                             out_pixel_y[11:0], out_last_pixel,
//                                             out_status[2:0]
//
// One byte per clock. Each accepted byte updates the parser state and, when
// it completes a pixel or reveals a header error, loads one result request.
// Results sit in a two-entry output buffer; in_ready is a flop and drops only
// while both entries are full, so the input keeps moving under a single
// stalled result. Reset (rst_n low, sync) leaves the parser waiting for a
// byte flagged in_file_start; bytes before that are dropped.
module bmp_stream_decoder
  import bmpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_file_start,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_pixel_argb,
  output logic [COORD_W-1:0]       out_pixel_x,
  output logic [COORD_W-1:0]       out_pixel_y,
  output logic                     out_last_pixel,
  output logic [STATUS_W-1:0]      out_status
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_PIXELS = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;

  // header byte offsets (offset of the last byte of each field)
  localparam logic [31:0] OFF_MAGIC  = 32'd1;
  localparam logic [31:0] OFF_PIXOFF = 32'd13;
  localparam logic [31:0] OFF_INFO   = 32'd17;
  localparam logic [31:0] OFF_WIDTH  = 32'd21;
  localparam logic [31:0] OFF_HEIGHT = 32'd25;
  localparam logic [31:0] OFF_BPP    = 32'd29;
  localparam logic [31:0] OFF_COMPR  = 32'd33;
  localparam logic [31:0] OFF_CHECK  = 32'd53;

  logic accept;
  assign accept = in_valid && in_ready;

  // parser state
  logic [2:0]            phase_r, phase_nxt;
  logic [31:0]           off_r, off_nxt;
  logic [31:0]           shift_r, shift_nxt;
  logic [31:0]           pix_off_r, pix_off_nxt;
  logic [31:0]           info_r, info_nxt;
  logic [31:0]           raw_w_r, raw_w_nxt;
  logic [31:0]           raw_h_r, raw_h_nxt;
  logic [15:0]           bpp_r, bpp_nxt;
  logic [31:0]           compr_r, compr_nxt;
  logic [WIDTH_W-1:0]    img_w_r, img_w_nxt;
  logic [HEIGHT_W-1:0]   img_h_r, img_h_nxt;
  logic                  bottom_up_r, bottom_up_nxt;
  logic                  four_bpp_r, four_bpp_nxt;
  logic [HEIGHT_W-1:0]   row_r, row_nxt;
  logic [ROW_BYTE_W-1:0] rb_r, rb_nxt;
  logic [1:0]            bip_r, bip_nxt;
  logic [WIDTH_W-1:0]    col_r, col_nxt;
  logic [7:0]            blue_r, blue_nxt;
  logic [7:0]            green_r, green_nxt;

  // header checks, from registered fields
  logic [31:0]           h_mag;
  logic                  size_bad, fmt_bad, offset_bad;
  // row geometry
  logic [ROW_BYTE_W-1:0] bytewidth, padded, rb_inc;
  logic [WIDTH_W:0]      w_times2;
  logic [1:0]            bip_last;
  logic [HEIGHT_W-1:0]   y_full;
  logic                  is_last;

  // per-byte working values
  logic [2:0]            ph_cur;
  logic [31:0]           off_cur, shift_cur, shift_new;
  logic                  do_pix;

  logic res_valid;
  res_t res;
  logic room;
  res_t out_data;

  always_comb begin
    h_mag      = raw_h_r[31] ? (32'd0 - raw_h_r) : raw_h_r;
    size_bad   = raw_w_r[31] || (raw_w_r == 32'd0) || (raw_w_r > 32'(MAX_WIDTH)) ||
                 (h_mag == 32'd0) || (h_mag > 32'(MAX_HEIGHT));
    fmt_bad    = !((bpp_r == BPP_24) || (bpp_r == BPP_32)) || (compr_r != 32'd0);
    offset_bad = {1'b0, pix_off_r} < (FILE_HDR_LEN + {1'b0, info_r});

    w_times2  = {img_w_r, 1'b0};
    bytewidth = four_bpp_r ? ROW_BYTE_W'({img_w_r, 2'b00})
                           : ROW_BYTE_W'(w_times2 + {1'b0, img_w_r});
    padded    = (bytewidth + ROW_BYTE_W'(3)) & ~ROW_BYTE_W'(3);
    rb_inc    = rb_r + ROW_BYTE_W'(1);
    bip_last  = four_bpp_r ? 2'd3 : 2'd2;
    y_full    = bottom_up_r ? (img_h_r - HEIGHT_W'(1) - row_r) : row_r;
    is_last   = ({1'b0, row_r} + (HEIGHT_W+1)'(1) == {1'b0, img_h_r}) &&
                ({1'b0, col_r} + (WIDTH_W+1)'(1) == {1'b0, img_w_r});
  end

  always_comb begin
    phase_nxt     = phase_r;
    off_nxt       = off_r;
    shift_nxt     = shift_r;
    pix_off_nxt   = pix_off_r;
    info_nxt      = info_r;
    raw_w_nxt     = raw_w_r;
    raw_h_nxt     = raw_h_r;
    bpp_nxt       = bpp_r;
    compr_nxt     = compr_r;
    img_w_nxt     = img_w_r;
    img_h_nxt     = img_h_r;
    bottom_up_nxt = bottom_up_r;
    four_bpp_nxt  = four_bpp_r;
    row_nxt       = row_r;
    rb_nxt        = rb_r;
    bip_nxt       = bip_r;
    col_nxt       = col_r;
    blue_nxt      = blue_r;
    green_nxt     = green_r;

    res_valid  = 1'b0;
    res.argb   = 32'd0;
    res.x      = '0;
    res.y      = '0;
    res.last   = 1'b0;
    res.status = ST_PIXEL;

    ph_cur    = in_file_start ? PH_HEADER : phase_r;
    off_cur   = in_file_start ? 32'd0 : off_r;
    shift_cur = in_file_start ? 32'd0 : shift_r;
    shift_new = {in_data_byte, shift_cur[31:8]};
    do_pix    = 1'b0;

    if (accept) begin
      // restart drops whatever the previous file left behind
      if (in_file_start) begin
        phase_nxt = PH_HEADER;
        row_nxt   = '0;
        rb_nxt    = '0;
        bip_nxt   = '0;
        col_nxt   = '0;
      end

      case (ph_cur)
        PH_HEADER: begin
          shift_nxt = shift_new;
          off_nxt   = off_cur + 32'd1;
          case (off_cur)
            OFF_MAGIC: begin
              if (shift_new[31:16] != {MAGIC_M, MAGIC_B}) begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res.status = ST_BAD_MAGIC;
              end
            end
            OFF_PIXOFF: pix_off_nxt = shift_new;
            OFF_INFO: begin
              info_nxt = shift_new;
              if (shift_new < MIN_INFO_SIZE) begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res.status = ST_INFO_SHORT;
              end
            end
            OFF_WIDTH:  raw_w_nxt = shift_new;
            OFF_HEIGHT: raw_h_nxt = shift_new;
            OFF_BPP:    bpp_nxt   = shift_new[31:16];
            OFF_COMPR:  compr_nxt = shift_new;
            OFF_CHECK: begin
              if (size_bad || fmt_bad || offset_bad) begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res.status = size_bad ? ST_BAD_SIZE :
                             fmt_bad  ? ST_BAD_FORMAT : ST_BAD_OFFSET;
              end else begin
                phase_nxt     = PH_SKIP;
                img_w_nxt     = raw_w_r[WIDTH_W-1:0];
                img_h_nxt     = h_mag[HEIGHT_W-1:0];
                bottom_up_nxt = !raw_h_r[31];
                four_bpp_nxt  = (bpp_r == BPP_32);
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          if (off_r != pix_off_r) begin
            off_nxt = off_r + 32'd1;
          end else begin
            phase_nxt = PH_PIXELS;
            do_pix    = 1'b1;
          end
        end
        PH_PIXELS: do_pix = 1'b1;
        default: ;
      endcase

      if (do_pix) begin
        if (rb_r < bytewidth) begin
          case (bip_r)
            2'd0: blue_nxt  = in_data_byte;
            2'd1: green_nxt = in_data_byte;
            2'd2: begin
              res_valid  = 1'b1;
              res.argb   = {ALPHA_OPAQUE, in_data_byte, green_r, blue_r};
              res.x      = col_r[COORD_W-1:0];
              res.y      = y_full[COORD_W-1:0];
              res.last   = is_last;
              res.status = ST_PIXEL;
            end
            default: ;
          endcase
          if (bip_r == bip_last) begin
            bip_nxt = 2'd0;
            col_nxt = col_r + WIDTH_W'(1);
          end else begin
            bip_nxt = bip_r + 2'd1;
          end
        end
        if (rb_inc >= padded) begin
          rb_nxt  = '0;
          bip_nxt = 2'd0;
          col_nxt = '0;
          row_nxt = row_r + HEIGHT_W'(1);
        end else begin
          rb_nxt = rb_inc;
        end
        // final pixel: everything after it is ignored
        if (res_valid && is_last && (bip_r == 2'd2)) begin
          phase_nxt = PH_HALT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      shift_r <= '0;
      row_r   <= '0;
      rb_r    <= '0;
      bip_r   <= '0;
      col_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      row_r   <= row_nxt;
      rb_r    <= rb_nxt;
      bip_r   <= bip_nxt;
      col_r   <= col_nxt;
    end
    pix_off_r   <= pix_off_nxt;
    info_r      <= info_nxt;
    raw_w_r     <= raw_w_nxt;
    raw_h_r     <= raw_h_nxt;
    bpp_r       <= bpp_nxt;
    compr_r     <= compr_nxt;
    img_w_r     <= img_w_nxt;
    img_h_r     <= img_h_nxt;
    bottom_up_r <= bottom_up_nxt;
    four_bpp_r  <= four_bpp_nxt;
    blue_r      <= blue_nxt;
    green_r     <= green_nxt;
  end

  bmpd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready       = room;
  assign out_pixel_argb = out_data.argb;
  assign out_pixel_x    = out_data.x;
  assign out_pixel_y    = out_data.y;
  assign out_last_pixel = out_data.last;
  assign out_status     = out_data.status;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Byte-stream BMP decoder bench: the driver feeds whole files (good, truncated
// and broken) one byte per request, the in-bench parser model predicts every
// pixel or error result, and the monitor checks them in order.
module testbench;
  import bmpd_pkg::*;

  // slowest legal run is well under this; it only catches a hang
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned PRINT_CAP   = 200;
  localparam int unsigned RANDOM_BYTES = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_file_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_argb;
  logic [COORD_W-1:0] out_pixel_x;
  logic [COORD_W-1:0] out_pixel_y;
  logic        out_last_pixel;
  logic [STATUS_W-1:0] out_status;

  bmp_stream_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_file_start (in_file_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_argb(out_pixel_argb),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel),
    .out_status    (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One byte request. drain: hold this byte back until every predicted
  // result has been collected.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       drain;
  } byte_req_t;

  // Header fields that the stimulus builder controls.
  typedef struct {
    logic [15:0] magic;
    logic [31:0] data_off;
    logic [31:0] info;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] bpp;
    logic [31:0] comp;
  } bmp_hdr_t;

  typedef enum logic [2:0] {
    PH_WAIT, PH_HEADER, PH_SKIP, PH_PIXELS, PH_HALT
  } parse_phase_e;

  byte_req_t   file_bytes_q[$];
  res_t        decoded_q[$];
  bit          drain_before_next = 1'b0;

  int unsigned bytes_accepted = 0;
  int unsigned total_bytes = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------
  parse_phase_e phase;
  logic [31:0]  hdr_offset;     // bytes consumed so far in header/skip
  logic [31:0]  shift_word;     // last four header bytes, little endian
  logic [31:0]  data_offset;    // pixel array offset from the file header
  logic [31:0]  info_len, w_raw, h_raw, comp_raw;
  logic [15:0]  bpp_raw;
  logic [12:0]  img_w, img_h, row_idx;
  logic [14:0]  row_pos;        // byte position within the padded row
  logic [1:0]   pix_byte;       // byte position within the pixel
  logic [7:0]   blue_b, green_b;
  logic         upside;         // bottom-up file: flip y
  logic         wide_px;        // 32 bpp

  function automatic void reset_parse_state();
    phase = PH_WAIT;
    hdr_offset = '0; shift_word = '0; data_offset = '0;
    info_len = '0; w_raw = '0; h_raw = '0; comp_raw = '0; bpp_raw = '0;
    img_w = '0; img_h = '0; row_idx = '0; row_pos = '0; pix_byte = '0;
    blue_b = '0; green_b = '0; upside = 1'b0; wide_px = 1'b0;
  endfunction

  // Consumes one file byte; returns 1 when it produces a result in r.
  function automatic bit bmp_parse_byte(input logic [7:0] b, input logic start,
                                        output res_t r);
    logic [31:0] off, mag, col, yrow, row_bytes, padded, bpb;
    logic [STATUS_W-1:0] err;
    logic fin, got_px;
    r = '0;
    if (start) begin
      reset_parse_state();
      phase = PH_HEADER;
    end

    if (phase == PH_HEADER) begin
      off = hdr_offset;
      shift_word = {b, shift_word[31:8]};
      hdr_offset = off + 1;
      err = ST_PIXEL;
      case (off)
        32'd1: if (shift_word[31:16] != {MAGIC_M, MAGIC_B}) err = ST_BAD_MAGIC;
        32'd13: data_offset = shift_word;
        32'd17: begin
          info_len = shift_word;
          if (info_len < MIN_INFO_SIZE) err = ST_INFO_SHORT;
        end
        32'd21: w_raw = shift_word;
        32'd25: h_raw = shift_word;
        32'd29: bpp_raw = shift_word[31:16];
        32'd33: comp_raw = shift_word;
        32'd53: begin
          // checks in priority order: size, format, pixel offset
          mag = h_raw[31] ? -h_raw : h_raw;
          if (w_raw[31] || w_raw == 0 || w_raw > MAX_WIDTH) err = ST_BAD_SIZE;
          else if (mag == 0 || mag > MAX_HEIGHT) err = ST_BAD_SIZE;
          else if (!(bpp_raw == BPP_24 || bpp_raw == BPP_32) || comp_raw != 0)
            err = ST_BAD_FORMAT;
          else if ({1'b0, data_offset} < FILE_HDR_LEN + {1'b0, info_len})
            err = ST_BAD_OFFSET;
          else begin
            img_w = w_raw[12:0];
            img_h = mag[12:0];
            upside = !h_raw[31];
            wide_px = (bpp_raw == BPP_32);
            phase = PH_SKIP;
          end
        end
        default: ;
      endcase
      if (err != ST_PIXEL) begin
        phase = PH_HALT;
        r.status = err;
        return 1'b1;
      end
      return 1'b0;
    end

    if (phase == PH_SKIP) begin
      if (hdr_offset != data_offset) begin
        hdr_offset = hdr_offset + 1;
        return 1'b0;
      end
      phase = PH_PIXELS;
    end

    if (phase == PH_PIXELS) begin
      bpb = wide_px ? 32'd4 : 32'd3;
      row_bytes = img_w * bpb;
      padded = (row_bytes + 3) & 32'h7fff_fffc;
      fin = 1'b0;
      got_px = 1'b0;
      if (row_pos < row_bytes) begin
        if (pix_byte == 0) blue_b = b;
        else if (pix_byte == 1) green_b = b;
        else if (pix_byte == 2) begin
          col = row_pos / bpb;
          yrow = upside ? (img_h - 1 - row_idx) : row_idx;
          fin = (row_idx + 1 == img_h) && (col + 1 == img_w);
          r.argb = {ALPHA_OPAQUE, b, green_b, blue_b};
          r.x = col[COORD_W-1:0];
          r.y = yrow[COORD_W-1:0];
          r.last = fin;
          r.status = ST_PIXEL;
          got_px = 1'b1;
          if (fin) begin
            phase = PH_HALT;
            return 1'b1;
          end
        end
        pix_byte = (pix_byte + 1 >= bpb) ? 2'd0 : pix_byte + 2'd1;
      end
      if (row_pos + 1 >= padded) begin
        row_pos = '0;
        pix_byte = '0;
        row_idx = row_idx + 1;
      end else begin
        row_pos = row_pos + 1;
      end
      return got_px;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic bmp_hdr_t plain_hdr(input logic [31:0] w, input logic [31:0] h,
                                         input logic [15:0] bpp);
    bmp_hdr_t hd;
    hd.magic = {MAGIC_M, MAGIC_B};
    hd.data_off = 32'd54;
    hd.info = MIN_INFO_SIZE;
    hd.w = w;
    hd.h = h;
    hd.bpp = bpp;
    hd.comp = '0;
    return hd;
  endfunction

  // Queues one file. keep < 0 sends the whole file, else only its first keep
  // bytes (a truncated file). tail bytes without a start flag follow.
  task automatic put_file(input bmp_hdr_t hd, input longint keep, input int tail);
    logic [7:0]  fb[$];
    logic [31:0] words[8];
    logic [31:0] mag, bpb, padded;
    longint      full_len, target;
    byte_req_t   req;
    fb.push_back(hd.magic[7:0]);
    fb.push_back(hd.magic[15:8]);
    // file size, reserved, offset, info size, width, height, planes+bpp, compression
    words = '{$urandom, $urandom, hd.data_off, hd.info, hd.w, hd.h,
              {hd.bpp, 16'($urandom)}, hd.comp};
    foreach (words[k])
      for (int i = 0; i < 4; i++) fb.push_back(words[k][8*i +: 8]);
    for (int i = 0; i < 20; i++) fb.push_back(8'($urandom));
    if (hd.data_off > 54 && hd.data_off <= 54 + 256)
      for (int i = 54; i < hd.data_off; i++) fb.push_back(8'($urandom));
    mag = hd.h[31] ? -hd.h : hd.h;
    full_len = fb.size();
    if (!hd.w[31] && hd.w != 0 && hd.w <= MAX_WIDTH && mag != 0 && mag <= MAX_HEIGHT) begin
      bpb = (hd.bpp == BPP_32) ? 32'd4 : 32'd3;
      padded = (hd.w * bpb + 3) & 32'h7fff_fffc;
      full_len += longint'(mag) * longint'(padded);
    end
    target = (keep >= 0 && keep < full_len) ? keep : full_len;
    while (fb.size() < target) begin
      // pixel bytes, biased toward the all-zero and all-one extremes
      case ($urandom_range(0, 9))
        0: fb.push_back(8'h00);
        1: fb.push_back(8'hff);
        default: fb.push_back(8'($urandom));
      endcase
    end
    for (int i = 0; i < target; i++) begin
      req.data = fb[i];
      req.start = (i == 0);
      req.drain = (i == 0) && drain_before_next;
      file_bytes_q.push_back(req);
    end
    drain_before_next = 1'b0;
    for (int i = 0; i < tail; i++) begin
      req.data = 8'($urandom);
      req.start = 1'b0;
      req.drain = 1'b0;
      file_bytes_q.push_back(req);
    end
  endtask

  // Idle length: mostly none, sometimes a few, rarely long. A calm stretch
  // forces a run of back-to-back cycles.
  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(30, 200);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] result %0d %s: got %h, expected %h",
               $realtime, result_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: pops byte requests, inserts random gaps, and feeds each accepted
  // byte to the parser model at the edge it is taken.
  // ---------------------------------------------------------------------
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  byte_req_t   next_req;
  res_t        predicted;
  bit          has_result;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        has_result = bmp_parse_byte(in_data_byte, in_file_start, predicted);
        if (has_result) decoded_q.push_back(predicted);
        bytes_accepted++;
      end
      // a pending request holds until taken
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (file_bytes_q.size() == 0 ||
                     (file_bytes_q[0].drain && decoded_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          next_req = file_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_req.data;
          in_file_start <= next_req.start;
          in_gap = pick_gap(in_calm);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, in-order compare against the model.
  // ---------------------------------------------------------------------
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;
  res_t        oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_status), '0);
        end else begin
          oldest = decoded_q.pop_front();
          if (out_pixel_argb !== oldest.argb)
            report_mismatch("pixel_argb", out_pixel_argb, oldest.argb);
          if (out_pixel_x !== oldest.x)
            report_mismatch("pixel_x", 32'(out_pixel_x), 32'(oldest.x));
          if (out_pixel_y !== oldest.y)
            report_mismatch("pixel_y", 32'(out_pixel_y), 32'(oldest.y));
          if (out_last_pixel !== oldest.last)
            report_mismatch("last_pixel", 32'(out_last_pixel), 32'(oldest.last));
          if (out_status !== oldest.status)
            report_mismatch("status", 32'(out_status), 32'(oldest.status));
        end
        result_count++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d of %0d bytes taken, %0d results pending",
               bytes_accepted, total_bytes, decoded_q.size());
      $display("bmp_stream_decoder test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : main
    bmp_hdr_t    hd;
    int unsigned kind, wd, ht, tail, q_size_prev, random_bytes;
    longint      keep;

    reset_parse_state();

    // directed: bytes before any file start are dropped
    put_file(plain_hdr(1, 1, BPP_24), 0, 4);
    // swapped magic, reported at byte 1, rest ignored
    hd = plain_hdr(1, 1, BPP_24);
    hd.magic = {MAGIC_B, MAGIC_M};
    put_file(hd, 6, 2);
    // info header one byte short of the minimum
    hd = plain_hdr(1, 1, BPP_24);
    hd.info = MIN_INFO_SIZE - 1;
    put_file(hd, 20, 0);
    // size limits: zero, one past max, sign bit, both height signs
    put_file(plain_hdr(0, 1, BPP_16_OR_BAD()), 54, 0);
    put_file(plain_hdr(MAX_WIDTH + 1, 1, BPP_24), 54, 0);
    put_file(plain_hdr(32'h8000_0000, 1, BPP_24), 54, 0);
    put_file(plain_hdr(1, 0, BPP_24), 54, 0);
    put_file(plain_hdr(1, MAX_HEIGHT + 1, BPP_24), 54, 0);
    put_file(plain_hdr(1, -(MAX_HEIGHT + 1), BPP_32), 54, 0);
    put_file(plain_hdr(1, 32'h8000_0000, BPP_24), 54, 0);
    // unsupported format: 16 bpp, then compression set
    put_file(plain_hdr(2, 2, 16'd16), 56, 0);
    hd = plain_hdr(2, 2, BPP_32);
    hd.comp = 32'd3;
    put_file(hd, 54, 0);
    // pixel offset back inside the header; huge info size must not wrap
    hd = plain_hdr(2, 2, BPP_24);
    hd.data_off = 32'd53;
    put_file(hd, 54, 0);
    hd = plain_hdr(2, 2, BPP_24);
    hd.info = 32'hffff_fff0;
    put_file(hd, 54, 0);
    // smallest images, both orientations and depths, trailing junk ignored
    put_file(plain_hdr(1, 1, BPP_24), -1, 3);
    put_file(plain_hdr(1, -1, BPP_32), -1, 0);
    // max width, top-down, cut short and restarted by the next file
    put_file(plain_hdr(MAX_WIDTH, -MAX_HEIGHT, BPP_32), 54 + 40, 0);
    // max height bottom-up (first row is y=4095), long info header and gap
    drain_before_next = 1'b1;
    hd = plain_hdr(MAX_WIDTH, MAX_HEIGHT, BPP_24);
    hd.info = 32'd124;
    hd.data_off = 32'd140;
    put_file(hd, 140 + 30, 0);
    // offset far past the data: parser skips forever until restart
    hd = plain_hdr(2, 2, BPP_24);
    hd.data_off = 32'h7fff_ffff;
    put_file(hd, 80, 0);
    // restart in the middle of the header
    put_file(plain_hdr(2, 2, BPP_24), 30, 0);
    // row padding at 24 bpp
    put_file(plain_hdr(3, 2, BPP_24), -1, 2);

    // random files: mostly well formed, some truncated, some broken
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      wd = $urandom_range(1, 5);
      ht = $urandom_range(1, 3);
      hd = plain_hdr(wd, $urandom_range(0, 1) ? ht : -ht,
                     $urandom_range(0, 1) ? BPP_32 : BPP_24);
      if ($urandom_range(0, 3) == 0) hd.info = MIN_INFO_SIZE + 4 * $urandom_range(1, 21);
      hd.data_off = 14 + hd.info + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0);
      keep = -1;
      if (kind >= 70 && kind < 82) begin
        keep = $urandom_range(1, 60 + wd * ht * 4);
      end else if (kind >= 82) begin
        case ($urandom_range(0, 7))
          0: do hd.magic = 16'($urandom); while (hd.magic == {MAGIC_M, MAGIC_B});
          1: hd.info = $urandom_range(0, MIN_INFO_SIZE - 1);
          2: hd.w = $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)};
          3: hd.w = MAX_WIDTH + 1 + $urandom_range(0, 5000);
          4: hd.h = (MAX_HEIGHT + 1 + $urandom_range(0, 5000)) *
                    ($urandom_range(0, 1) ? 1 : -1);
          5: do hd.bpp = 16'($urandom); while (hd.bpp == BPP_24 || hd.bpp == BPP_32);
          6: hd.comp = $urandom_range(1, 6);
          default: hd.data_off = 14 + hd.info - $urandom_range(1, 54);
        endcase
      end
      drain_before_next = ($urandom_range(0, 15) == 0);
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      q_size_prev = file_bytes_q.size();
      put_file(hd, keep, tail);
      random_bytes += file_bytes_q.size() - q_size_prev - tail;
    end
    total_bytes = file_bytes_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted != total_bytes) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    // let any stray result still in the output buffer come out
    repeat (40) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch("results never produced", decoded_q.size(), '0);

    if (mismatch_count == 0) begin
      $display("bmp_stream_decoder test passed");
    end else begin
      $display("bmp_stream_decoder test failed");
    end
    $finish;
  end

  // unsupported depth used with a zero width, so the size error must win
  function automatic logic [15:0] BPP_16_OR_BAD();
    return 16'd16;
  endfunction

endmodule

// ===== files.f =====
design/bmpd_pkg.sv
design/bmpd_skid.sv
design/bmp_stream_decoder.sv
tb/sv/testbench.sv
